### rtl/msv_pkg.sv
package msv_pkg;

  // Field and register widths
  localparam int KIND_W     = 2;
  localparam int PIDX_W     = 4;
  localparam int INC_W      = 32;
  localparam int LEN_W      = 24;
  localparam int PCNT_W     = 5;
  localparam int MODE_W     = 2;
  localparam int SAMPLE_W   = 16;
  localparam int SMAG_W     = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int DIV_ITER_W = 6;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_START = 2'd2;

  // Voice modes
  localparam logic [MODE_W-1:0] MODE_CONST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GLIDE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CHORD = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONST_INC   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GLIDE_START = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GLIDE_END   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NOTE_LEN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PART_COUNT  = 3'd5;

  // Quarter-wave polynomial, Q30
  localparam longint SINE_Q30 = 64'sd1073741824;
  localparam longint SINE_C0  = 64'sd1686629713;
  localparam longint SINE_C1  = 64'sd693598668;
  localparam longint SINE_C2  = 64'sd85569306;
  localparam longint SINE_C3  = 64'sd5026995;
  localparam longint SINE_C4  = 64'sd172272;

  typedef struct packed {
    logic clear;
    logic shift;
    logic load;
  } cell_ctl_t;

  typedef struct packed {
    logic                  start;
    logic [DIV_ITER_W-1:0] iters;
  } div_req_t;

  // Magnitude of one quarter-wave point at distance d from the zero crossing
  function automatic logic [SMAG_W-1:0] sine_mag(input int d, input int tbits);
    longint x;
    longint x2;
    longint p;
    longint y;
    x  = longint'(d) <<< (30 - (tbits - 2));
    x2 = x * x / SINE_Q30;
    p  = SINE_C4;
    p  = SINE_C3 - p * x2 / SINE_Q30;
    p  = SINE_C2 - p * x2 / SINE_Q30;
    p  = SINE_C1 - p * x2 / SINE_Q30;
    p  = SINE_C0 - p * x2 / SINE_Q30;
    y  = p * x / SINE_Q30;
    if (y < 0) y = 0;
    y = (y * 32767 + SINE_Q30 / 2) / SINE_Q30;
    if (y > 32767) y = 32767;
    return SMAG_W'(y);
  endfunction

endpackage

### rtl/msv_cell.sv
module msv_cell #(
  parameter int PHASE_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  msv_pkg::cell_ctl_t         ctl,
  input  logic [msv_pkg::INC_W-1:0]  load_inc,
  input  logic [PHASE_BITS-1:0]      nb_phase,
  input  logic [msv_pkg::INC_W-1:0]  nb_inc,
  output logic [PHASE_BITS-1:0]      phase,
  output logic [msv_pkg::INC_W-1:0]  inc
);
  import msv_pkg::*;

  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic [INC_W-1:0]      inc_r, inc_nxt;

  // Clear on note start, take the neighbour's pair on a shift, take a new increment on load
  always_comb begin
    phase_nxt = phase_r;
    inc_nxt   = inc_r;
    priority if (ctl.clear) begin
      phase_nxt = '0;
    end else if (ctl.shift) begin
      phase_nxt = nb_phase;
      inc_nxt   = nb_inc;
    end else begin
      phase_nxt = phase_r;
    end
    if (ctl.load) begin
      inc_nxt = load_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      inc_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      inc_r   <= inc_nxt;
    end
  end

  assign phase = phase_r;
  assign inc   = inc_r;

endmodule

### rtl/msv_sine_rom.sv
module msv_sine_rom #(
  parameter int TABLE_BITS = 10
) (
  input  logic                                clk,
  input  logic [TABLE_BITS-1:0]               idx,
  output logic signed [msv_pkg::SAMPLE_W-1:0] sample
);
  import msv_pkg::*;

  localparam int QTR    = 1 << (TABLE_BITS - 2);
  localparam int ADDR_W = TABLE_BITS - 1;

  logic [SMAG_W-1:0] rom [QTR+1];
  logic [1:0]        quad;
  logic [ADDR_W-1:0] r_ext;
  logic [ADDR_W-1:0] addr;
  logic [SMAG_W-1:0] mag_r;
  logic              neg_r;

  // Build the quarter wave at elaboration
  for (genvar d = 0; d <= QTR; d++) begin : g_pt
    assign rom[d] = sine_mag(d, TABLE_BITS);
  end

  // Fold the index into the quarter wave
  assign quad  = idx[TABLE_BITS-1 -: 2];
  assign r_ext = {1'b0, idx[TABLE_BITS-3:0]};
  assign addr  = quad[0] ? ADDR_W'(QTR) - r_ext : r_ext;

  always_ff @(posedge clk) begin
    mag_r <= rom[addr];
    neg_r <= quad[1];
  end

  // Apply the half-period sign
  assign sample = neg_r ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});

endmodule

### rtl/msv_divider.sv
module msv_divider #(
  parameter int DVD_W = 56,
  parameter int DVS_W = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  msv_pkg::div_req_t  req,
  input  logic [DVD_W-1:0]   dividend,
  input  logic [DVS_W-1:0]   divisor,
  output logic               busy,
  output logic [DVD_W-1:0]   quotient
);
  import msv_pkg::*;

  logic [DVD_W-1:0]      quo_r;
  logic [DVS_W-1:0]      rem_r;
  logic [DVS_W-1:0]      dvs_r;
  logic [DIV_ITER_W-1:0] cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic [DVS_W:0]        rem_sh;
  logic [DVS_W:0]        rem_sub;
  logic                  ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_sh  = {rem_r, quo_r[DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};
  assign ge      = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (req.start) begin
      cnt_nxt  = req.iters;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      cnt_nxt  = cnt_r - DIV_ITER_W'(1);
      busy_nxt = cnt_r != DIV_ITER_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
    end
  end

  // Datapath: quotient bits enter at the bottom as the dividend leaves the top
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DVD_W-2:0], ge};
      rem_r <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

### rtl/multimode_sine_voice.sv
// Channel   Direction  Beat contents
// in_       in         kind, partial_index, partial_increment
// out_      out        sample, note_done (one beat per tick)
// cfg_      in         write enable, register index, write data
//
// A tick runs DR1, DR2 and EMIT in constant mode; GMUL, DSTART, DWAIT, GADD, DR1, DR2 and
// EMIT in glide mode (one quotient bit per cycle in the shared divider); and one turn of the
// partial ring, DR1, DR2, then the divider and EMIT in chord mode; a finished note, an empty
// chord or the unused mode goes straight to EMIT, and load and start beats stay in IDLE.
// Reset is synchronous and clears all partial phases and increments, the main phase and the sample counter.
// A new beat is taken while a result waits; a stalled output holds the next tick at EMIT.
module multimode_sine_voice #(
  parameter int MAX_PARTIALS    = 16,
  parameter int PHASE_BITS      = 32,
  parameter int SINE_TABLE_BITS = 10,
  parameter int COUNT_BITS      = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [msv_pkg::KIND_W-1:0]            in_kind,
  input  logic [msv_pkg::PIDX_W-1:0]            in_partial_index,
  input  logic [msv_pkg::INC_W-1:0]             in_partial_increment,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [msv_pkg::SAMPLE_W-1:0]   out_sample,
  output logic                                  out_note_done,
  input  logic                                  cfg_we,
  input  logic [msv_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [msv_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
  import msv_pkg::*;

  localparam int CNT_W = $clog2(MAX_PARTIALS + 1);
  localparam int RC_W  = (MAX_PARTIALS > 1) ? $clog2(MAX_PARTIALS) : 1;
  localparam int ACC_W = SAMPLE_W + $clog2(MAX_PARTIALS);
  localparam int MAG_W = ACC_W - 1;
  localparam int N_W   = (COUNT_BITS < LEN_W) ? COUNT_BITS : LEN_W;
  localparam int DVD_W = INC_W + N_W;
  localparam int DVS_W = LEN_W;
  localparam int STB   = SINE_TABLE_BITS;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_ROT    = 4'd1;
  localparam logic [3:0] ST_DR1    = 4'd2;
  localparam logic [3:0] ST_DR2    = 4'd3;
  localparam logic [3:0] ST_GMUL   = 4'd4;
  localparam logic [3:0] ST_DSTART = 4'd5;
  localparam logic [3:0] ST_DWAIT  = 4'd6;
  localparam logic [3:0] ST_GADD   = 4'd7;
  localparam logic [3:0] ST_EMIT   = 4'd8;

  // Configuration registers
  logic [MODE_W-1:0] mode_r;
  logic [INC_W-1:0]  const_inc_r;
  logic [INC_W-1:0]  glide_start_r;
  logic [INC_W-1:0]  glide_end_r;
  logic [LEN_W-1:0]  note_len_r;
  logic [PCNT_W-1:0] pcount_r;

  // Control and state
  logic [3:0]             state_r, state_nxt;
  logic [RC_W-1:0]        rot_cnt_r, rot_cnt_nxt;
  logic [PHASE_BITS-1:0]  main_phase_r, main_phase_nxt;
  logic [COUNT_BITS-1:0]  counter_r, counter_nxt;
  logic                   lk_vld_r, lk_vld_nxt;
  logic                   mag_vld_r;
  logic                   out_valid_r, out_valid_nxt;

  // Datapath registers
  logic [STB-1:0]             lk_idx_r, lk_idx_nxt;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt, acc_sum;
  logic                       gl_neg_r, gl_neg_nxt;
  logic [INC_W-1:0]           gl_mag_r, gl_mag_nxt;
  logic [N_W-1:0]             gl_n_r, gl_n_nxt;
  logic [DVD_W-1:0]           prod_r, prod_nxt;
  logic [INC_W-1:0]           inc_r, inc_nxt;
  logic signed [SAMPLE_W-1:0] res_sample_r, res_sample_nxt;
  logic                       res_done_r, res_done_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_note_done_r;
  logic                       out_load;

  // Ring and lookup
  cell_ctl_t             cell_ctl   [MAX_PARTIALS];
  logic [PHASE_BITS-1:0] cell_phase [MAX_PARTIALS];
  logic [INC_W-1:0]      cell_inc   [MAX_PARTIALS];
  logic [PHASE_BITS-1:0] nb_phase   [MAX_PARTIALS];
  logic [INC_W-1:0]      nb_inc     [MAX_PARTIALS];
  logic [PHASE_BITS-1:0] head_upd;
  logic                  head_act;
  logic signed [SAMPLE_W-1:0] rom_sample;
  logic [PHASE_BITS-1:0] main_add;

  // Divider hookup
  div_req_t         div_req;
  logic [DVD_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic             div_busy;
  logic [DVD_W-1:0] div_quot;

  logic             in_fire;
  logic             load_acc;
  logic             clear_acc;
  logic             note_over;
  logic [CNT_W-1:0] cnt_sat;
  logic [LEN_W-1:0] den;
  logic [ACC_W-1:0] acc_abs;
  logic [SAMPLE_W-1:0] q16;
  logic [INC_W-1:0] q32;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_CONST;
      const_inc_r   <= '0;
      glide_start_r <= '0;
      glide_end_r   <= '0;
      note_len_r    <= LEN_W'(1);
      pcount_r      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:        mode_r        <= cfg_wdata[MODE_W-1:0];
        REG_CONST_INC:   const_inc_r   <= cfg_wdata[INC_W-1:0];
        REG_GLIDE_START: glide_start_r <= cfg_wdata[INC_W-1:0];
        REG_GLIDE_END:   glide_end_r   <= cfg_wdata[INC_W-1:0];
        REG_NOTE_LEN:    note_len_r    <= cfg_wdata[LEN_W-1:0];
        REG_PART_COUNT:  pcount_r      <= cfg_wdata[PCNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready  = state_r == ST_IDLE;
  assign in_fire   = in_valid && in_ready;
  assign load_acc  = in_fire && (in_kind == KIND_LOAD);
  assign clear_acc = in_fire && (in_kind == KIND_START);
  assign note_over = 32'(counter_r) >= 32'(note_len_r);
  assign cnt_sat   = (32'(pcount_r) > 32'(MAX_PARTIALS)) ? CNT_W'(MAX_PARTIALS)
                                                        : CNT_W'(pcount_r);
  assign den       = (note_len_r > LEN_W'(1)) ? note_len_r - LEN_W'(1) : LEN_W'(1);

  // Partial ring: the head updates and wraps to the tail
  assign head_act = 32'(rot_cnt_r) < 32'(cnt_sat);
  assign head_upd = head_act ? cell_phase[0] + PHASE_BITS'(cell_inc[0]) : cell_phase[0];

  for (genvar i = 0; i < MAX_PARTIALS; i++) begin : g_cell
    if (i == MAX_PARTIALS - 1) begin : g_tail
      assign nb_phase[i] = head_upd;
      assign nb_inc[i]   = cell_inc[0];
    end else begin : g_mid
      assign nb_phase[i] = cell_phase[i+1];
      assign nb_inc[i]   = cell_inc[i+1];
    end

    assign cell_ctl[i].clear = clear_acc;
    assign cell_ctl[i].shift = state_r == ST_ROT;
    assign cell_ctl[i].load  = load_acc && (32'(in_partial_index) == 32'(i));

    msv_cell #(
      .PHASE_BITS (PHASE_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (cell_ctl[i]),
      .load_inc (in_partial_increment),
      .nb_phase (nb_phase[i]),
      .nb_inc   (nb_inc[i]),
      .phase    (cell_phase[i]),
      .inc      (cell_inc[i])
    );
  end

  // Shared sine lookup
  msv_sine_rom #(
    .TABLE_BITS (STB)
  ) u_rom (
    .clk    (clk),
    .idx    (lk_idx_r),
    .sample (rom_sample)
  );

  // Shared divider: glide ramp and chord mean
  assign acc_abs = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  assign div_dvd = (mode_r == MODE_CHORD)
                 ? (DVD_W'(acc_abs[MAG_W-1:0]) << (DVD_W - MAG_W)) : prod_r;
  assign div_dvs = (mode_r == MODE_CHORD) ? DVS_W'(cnt_sat) : den;
  assign div_req.iters = (mode_r == MODE_CHORD) ? DIV_ITER_W'(MAG_W) : DIV_ITER_W'(DVD_W);
  assign div_req.start = state_r == ST_DSTART;

  msv_divider #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  assign q16 = div_quot[SAMPLE_W-1:0];
  assign q32 = div_quot[INC_W-1:0];

  // Main phase step and sample accumulation
  assign main_add = main_phase_r
                  + PHASE_BITS'((state_r == ST_GADD) ? inc_r : const_inc_r);
  assign acc_sum  = mag_vld_r ? acc_r + ACC_W'(rom_sample) : acc_r;

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    rot_cnt_nxt    = rot_cnt_r;
    main_phase_nxt = main_phase_r;
    counter_nxt    = counter_r;
    lk_vld_nxt     = 1'b0;
    lk_idx_nxt     = lk_idx_r;
    acc_nxt        = acc_sum;
    gl_neg_nxt     = gl_neg_r;
    gl_mag_nxt     = gl_mag_r;
    gl_n_nxt       = gl_n_r;
    prod_nxt       = prod_r;
    inc_nxt        = inc_r;
    res_sample_nxt = res_sample_r;
    res_done_nxt   = res_done_r;
    out_load       = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_kind)
            KIND_START: begin
              main_phase_nxt = '0;
              counter_nxt    = '0;
            end
            KIND_TICK: begin
              acc_nxt        = '0;
              res_sample_nxt = '0;
              res_done_nxt   = note_over;
              if (note_over) begin
                state_nxt = ST_EMIT;
              end else begin
                counter_nxt = counter_r + COUNT_BITS'(1);
                unique case (mode_r)
                  MODE_CONST: begin
                    main_phase_nxt = main_add;
                    lk_idx_nxt     = main_add[PHASE_BITS-1 -: STB];
                    lk_vld_nxt     = 1'b1;
                    state_nxt      = ST_DR1;
                  end
                  MODE_GLIDE: begin
                    gl_neg_nxt = glide_end_r < glide_start_r;
                    gl_mag_nxt = (glide_end_r < glide_start_r)
                               ? glide_start_r - glide_end_r
                               : glide_end_r - glide_start_r;
                    gl_n_nxt   = N_W'(counter_r);
                    state_nxt  = ST_GMUL;
                  end
                  MODE_CHORD: begin
                    rot_cnt_nxt = '0;
                    state_nxt   = (cnt_sat == '0) ? ST_EMIT : ST_ROT;
                  end
                  default: state_nxt = ST_EMIT;
                endcase
              end
            end
            default: ;
          endcase
        end
      end
      ST_ROT: begin
        lk_idx_nxt = head_upd[PHASE_BITS-1 -: STB];
        lk_vld_nxt = head_act;
        if (rot_cnt_r == RC_W'(MAX_PARTIALS - 1)) begin
          rot_cnt_nxt = '0;
          state_nxt   = ST_DR1;
        end else begin
          rot_cnt_nxt = rot_cnt_r + RC_W'(1);
        end
      end
      ST_DR1: state_nxt = ST_DR2;
      ST_DR2: begin
        if (mode_r == MODE_CHORD) begin
          state_nxt = ST_DSTART;
        end else begin
          res_sample_nxt = acc_sum[SAMPLE_W-1:0];
          state_nxt      = ST_EMIT;
        end
      end
      ST_GMUL: begin
        prod_nxt  = DVD_W'(gl_mag_r) * DVD_W'(gl_n_r);
        state_nxt = ST_DSTART;
      end
      ST_DSTART: state_nxt = ST_DWAIT;
      ST_DWAIT: begin
        if (!div_busy) begin
          if (mode_r == MODE_CHORD) begin
            res_sample_nxt = acc_r[ACC_W-1] ? -$signed(q16) : $signed(q16);
            state_nxt      = ST_EMIT;
          end else begin
            inc_nxt   = gl_neg_r ? glide_start_r - q32 : glide_start_r + q32;
            state_nxt = ST_GADD;
          end
        end
      end
      ST_GADD: begin
        main_phase_nxt = main_add;
        lk_idx_nxt     = main_add[PHASE_BITS-1 -: STB];
        lk_vld_nxt     = 1'b1;
        state_nxt      = ST_DR1;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output register: hold until taken
  assign out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rot_cnt_r    <= '0;
      main_phase_r <= '0;
      counter_r    <= '0;
      lk_vld_r     <= 1'b0;
      mag_vld_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rot_cnt_r    <= rot_cnt_nxt;
      main_phase_r <= main_phase_nxt;
      counter_r    <= counter_nxt;
      lk_vld_r     <= lk_vld_nxt;
      mag_vld_r    <= lk_vld_r;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lk_idx_r     <= lk_idx_nxt;
    acc_r        <= acc_nxt;
    gl_neg_r     <= gl_neg_nxt;
    gl_mag_r     <= gl_mag_nxt;
    gl_n_r       <= gl_n_nxt;
    prod_r       <= prod_nxt;
    inc_r        <= inc_nxt;
    res_sample_r <= res_sample_nxt;
    res_done_r   <= res_done_nxt;
    if (out_load) begin
      out_sample_r    <= res_sample_r;
      out_note_done_r <= res_done_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_sample    = out_sample_r;
  assign out_note_done = out_note_done_r;

  // Checks
  a_ready_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !div_busy)
    else $error("input taken while divider busy");

  a_setup_beat_no_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_kind == KIND_LOAD || in_kind == KIND_START)) |=> state_r == ST_IDLE)
    else $error("load or start beat left the idle state");

  a_ring_home: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_ROT) |-> rot_cnt_r == '0)
    else $error("partial ring not at home position");

  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_note_done) |-> out_sample == '0)
    else $error("finished note gave a non-zero sample");

  a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && (!out_valid_r || out_ready)) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("result not moved to output register");

endmodule
